// File: hw/rtl/far_pkg.sv
// Shared constants, codes and types of the frame allocator.
package far_pkg;

    localparam int FRAME_COUNT = 16;
    localparam int FRAME_BYTES = 256;

    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int OFFS_W    = $clog2(FRAME_BYTES);
    localparam int MEM_DEPTH = FRAME_COUNT * FRAME_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [8:0]  FRAME_LIM = 9'(FRAME_COUNT);
    localparam logic [12:0] OFFS_LIM  = 13'(FRAME_BYTES);

    localparam logic signed [15:0] NO_PAGE = -16'sd1;

    typedef enum logic [2:0] {
        REQ_ALLOC   = 3'd0,
        REQ_FREE    = 3'd1,
        REQ_READ    = 3'd2,
        REQ_WRITE   = 3'd3,
        REQ_GET_MAP = 3'd4,
        REQ_SET_MAP = 3'd5
    } t_req_code;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_VICTIM = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [7:0]         frame_index;
        logic               frame_ok;
        logic               offs_ok;
        logic signed [15:0] page_number;
    } t_cmd;

    typedef struct packed {
        logic [7:0]         frame_out;
        logic [7:0]         read_data;
        logic signed [15:0] mapped_page;
        logic [1:0]         status;
    } t_result;

endpackage

// File: hw/rtl/far_req_if.sv
// Request channel of the frame allocator.
interface far_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [7:0]         frame_index;
    logic [11:0]        byte_offset;
    logic [7:0]         write_data;
    logic signed [15:0] page_number;

    modport source (
        output valid, req_type, frame_index, byte_offset, write_data, page_number,
        input  ready
    );
    modport sink (
        input  valid, req_type, frame_index, byte_offset, write_data, page_number,
        output ready
    );
endinterface

// File: hw/rtl/far_rsp_if.sv
// Result channel of the frame allocator.
interface far_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         frame_out;
    logic [7:0]         read_data;
    logic signed [15:0] mapped_page;
    logic [1:0]         status;

    modport source (
        output valid, frame_out, read_data, mapped_page, status,
        input  ready
    );
    modport sink (
        input  valid, frame_out, read_data, mapped_page, status,
        output ready
    );
endinterface

// File: hw/rtl/far_ram.sv
// Generic single-port RAM with registered read.
module far_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/far_table.sv
// Frame flags, frame-to-page map, victim pointer and result formation.
module far_table import far_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_cmd    i_cmd,
    input  logic [7:0] i_rdata,
    output t_result o_result
);

    logic [FRAME_COUNT-1:0] r_used, n_used;
    logic signed [15:0]     r_page [FRAME_COUNT];
    logic signed [15:0]     n_page [FRAME_COUNT];
    logic [FRAME_W-1:0]     r_victim, n_victim;
    logic [FRAME_W-1:0]     free_idx;
    logic [FRAME_W-1:0]     fsel;
    logic                   any_free;
    t_result                res;

    assign fsel     = i_cmd.frame_index[FRAME_W-1:0];
    assign any_free = ~&r_used;

    // lowest free frame wins
    always_comb begin
        free_idx = '0;
        for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
            if (!r_used[f]) begin
                free_idx = FRAME_W'(f);
            end
        end
    end

    always_comb begin
        n_used          = r_used;
        n_page          = r_page;
        n_victim        = r_victim;
        res.frame_out   = '0;
        res.read_data   = '0;
        res.mapped_page = NO_PAGE;
        res.status      = ST_DONE;
        case (i_cmd.req_type)
            REQ_ALLOC: begin
                if (any_free) begin
                    n_used[free_idx] = 1'b1;
                    res.frame_out    = 8'(free_idx);
                end else begin
                    res.frame_out = 8'(r_victim);
                    res.status    = ST_VICTIM;
                    if (r_victim == FRAME_W'(FRAME_COUNT - 1)) begin
                        n_victim = '0;
                    end else begin
                        n_victim = r_victim + 1'b1;
                    end
                end
            end
            REQ_FREE: begin
                if (i_cmd.frame_ok) begin
                    n_used[fsel] = 1'b0;
                    n_page[fsel] = NO_PAGE;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            REQ_READ: begin
                if (i_cmd.frame_ok && i_cmd.offs_ok) begin
                    res.read_data = i_rdata;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            REQ_WRITE: begin
                // the byte store was written when the request was taken
                if (!(i_cmd.frame_ok && i_cmd.offs_ok)) begin
                    res.status = ST_RANGE;
                end
            end
            REQ_GET_MAP: begin
                if (i_cmd.frame_ok) begin
                    res.mapped_page = r_page[fsel];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            REQ_SET_MAP: begin
                if (i_cmd.frame_ok) begin
                    n_page[fsel] = i_cmd.page_number;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: begin
                res.status = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_victim <= '0;
            for (int f = 0; f < FRAME_COUNT; f++) begin
                r_page[f] <= NO_PAGE;
            end
        end else if (i_fire) begin
            r_used   <= n_used;
            r_victim <= n_victim;
            r_page   <= n_page;
        end
    end

    assign o_result = res;

endmodule

// File: hw/rtl/frame_allocator_round_robin.sv
// Frame allocator top level: request register, byte store, result register.
//
// Requests arrive on i_req (valid/ready); each request gives exactly one
// result on o_rsp (valid/ready), in request order. A transfer happens at a
// rising edge with valid and ready both high.
// Each request passes the request and result registers on its way to o_rsp.
// Throughput: one request per cycle unless o_rsp stalls or the clearing pass
// runs, set by the single-port byte store, which does one read or one write
// per request as it is taken. Allocation is a combinational search of the
// in-use flags; with every frame in use it grants the round-robin victim and
// reports status 2. Reset (i_rst_n low, synchronous) clears flags, victim
// pointer, map (to -1) and both pipeline stages, then zeroes the store's
// FRAME_COUNT * FRAME_BYTES bytes (4096 by default) with i_req.ready low.
// When the receiver holds o_rsp.ready low, the result stays on o_rsp, the
// request register fills, and i_req.ready drops until the result is taken.
module frame_allocator_round_robin import far_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    far_req_if.sink   i_req,
    far_rsp_if.source o_rsp
);

    logic              r_clr_busy;
    logic [MEM_AW-1:0] r_clr_addr;
    logic              r_in_valid;
    t_cmd              r_cmd;
    logic              r_out_valid;
    t_result           r_out;

    logic              adv;
    logic              in_ready;
    logic              in_xfer;
    logic              fire;
    logic              frame_ok;
    logic              offs_ok;
    logic [MEM_AW-1:0] req_addr;
    logic              ram_en;
    logic              ram_we;
    logic [MEM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    t_result           result;

    assign adv      = !r_out_valid || o_rsp.ready;
    assign in_ready = !r_clr_busy && (!r_in_valid || adv);
    assign in_xfer  = i_req.valid && in_ready;
    assign fire     = r_in_valid && adv;

    assign frame_ok = {1'b0, i_req.frame_index} < FRAME_LIM;
    assign offs_ok  = {1'b0, i_req.byte_offset} < OFFS_LIM;
    assign req_addr = MEM_AW'(MEM_AW'(i_req.frame_index[FRAME_W-1:0]) * MEM_AW'(FRAME_BYTES))
                    + MEM_AW'(i_req.byte_offset[OFFS_W-1:0]);

    // byte store port: clearing pass first, then one access per request transfer
    always_comb begin
        if (r_clr_busy) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_en    = in_xfer;
            ram_we    = (i_req.req_type == REQ_WRITE) && frame_ok && offs_ok;
            ram_addr  = req_addr;
            ram_wdata = i_req.write_data;
        end
    end

    far_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_bytes (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    far_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (r_cmd),
        .i_rdata  (ram_rdata),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_ready) begin
                r_in_valid <= in_xfer;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers: hold unless advancing
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd.req_type    <= i_req.req_type;
            r_cmd.frame_index <= i_req.frame_index;
            r_cmd.frame_ok    <= frame_ok;
            r_cmd.offs_ok     <= offs_ok;
            r_cmd.page_number <= i_req.page_number;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.frame_out   = r_out.frame_out;
    assign o_rsp.read_data   = r_out.read_data;
    assign o_rsp.mapped_page = r_out.mapped_page;
    assign o_rsp.status      = r_out.status;

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_in_valid && !r_out_valid)
        else $error("pipeline holds a request during the clearing pass");

    a_clear_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_addr) == MEM_AW'(MEM_DEPTH - 1))
        else $error("clearing pass ended early");

    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_cmd))
        else $error("request register lost a stalled request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.status == ST_DONE || r_out.status == ST_RANGE
                        || r_out.status == ST_VICTIM)
        else $error("result carries an undefined status code");

endmodule

// File: bench/tb_frame_allocator_round_robin.sv
// Self-checking testbench of the frame allocator: directed and random requests.
`timescale 1ns / 100ps

module tb_frame_allocator_round_robin import far_pkg::*;;

    localparam int          WATCHDOG_CYCLES = 20000;
    localparam int          ITEMS_PER_PHASE = 475;
    localparam logic [2:0]  REQ_RSVD_A      = 3'd6;
    localparam logic [2:0]  REQ_RSVD_B      = 3'd7;

    // Tracks allocator state and holds the results owed to the result channel.
    class frame_board;
        bit                 used [FRAME_COUNT];
        logic signed [15:0] page_map [FRAME_COUNT];
        logic [7:0]         frame_mem [MEM_DEPTH];
        bit [7:0]           victim;
        t_result            owed_q [$];
        int                 errors;

        function new();
            for (int f = 0; f < FRAME_COUNT; f++) begin
                used[f]     = 1'b0;
                page_map[f] = NO_PAGE;
            end
            for (int a = 0; a < MEM_DEPTH; a++)
                frame_mem[a] = 8'h00;
            victim = 8'd0;
            errors = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_request(logic [2:0] rt, logic [7:0] fi, logic [11:0] off,
                                   logic [7:0] wd, logic signed [15:0] pg);
            t_result r;
            bit      fok;
            bit      ook;
            int      slot;
            int      addr;
            r.frame_out   = 8'd0;
            r.read_data   = 8'd0;
            r.mapped_page = NO_PAGE;
            r.status      = ST_DONE;
            fok  = int'(fi) < FRAME_COUNT;
            ook  = int'(off) < FRAME_BYTES;
            addr = int'(fi) * FRAME_BYTES + int'(off);
            case (rt)
                REQ_ALLOC: begin
                    slot = FRAME_COUNT;
                    for (int f = FRAME_COUNT - 1; f >= 0; f--)
                        if (!used[f]) slot = f;
                    if (slot < FRAME_COUNT) begin
                        used[slot]  = 1'b1;
                        r.frame_out = 8'(slot);
                    end else begin
                        // every frame taken: grant the victim, leave flags and map alone
                        r.frame_out = victim;
                        victim      = 8'((int'(victim) + 1) % FRAME_COUNT);
                        r.status    = ST_VICTIM;
                    end
                end
                REQ_FREE: begin
                    if (fok) begin
                        used[fi]     = 1'b0;
                        page_map[fi] = NO_PAGE;
                    end else r.status = ST_RANGE;
                end
                REQ_READ: begin
                    if (fok && ook) r.read_data = frame_mem[addr];
                    else r.status = ST_RANGE;
                end
                REQ_WRITE: begin
                    if (fok && ook) frame_mem[addr] = wd;
                    else r.status = ST_RANGE;
                end
                REQ_GET_MAP: begin
                    if (fok) r.mapped_page = page_map[fi];
                    else r.status = ST_RANGE;
                end
                REQ_SET_MAP: begin
                    if (fok) page_map[fi] = pg;
                    else r.status = ST_RANGE;
                end
                default: r.status = ST_RANGE;
            endcase
            owed_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                $error("unexpected result: frame_out=%0d read_data=%0d mapped_page=%0d status=%0d",
                       got.frame_out, got.read_data, got.mapped_page, got.status);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.frame_out !== want.frame_out) begin
                $error("frame_out: expected %0d, got %0d", want.frame_out, got.frame_out);
                errors++;
            end
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
                errors++;
            end
            if (got.mapped_page !== want.mapped_page) begin
                $error("mapped_page: expected %0d, got %0d", want.mapped_page, got.mapped_page);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    far_req_if req_ch ();
    far_rsp_if rsp_ch ();

    frame_allocator_round_robin i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    frame_board board;
    int         src_idle_pct;
    int         snk_stall_pct;
    int         quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor both channels on pre-edge values; watch for a hung block.
    always @(posedge i_clk) begin : monitor
        t_result seen;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                board.note_request(req_ch.req_type, req_ch.frame_index, req_ch.byte_offset,
                                   req_ch.write_data, req_ch.page_number);
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.frame_out   = rsp_ch.frame_out;
                seen.read_data   = rsp_ch.read_data;
                seen.mapped_page = rsp_ch.mapped_page;
                seen.status      = rsp_ch.status;
                board.check_result(seen);
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_req(logic [2:0] rt, logic [7:0] fi, logic [11:0] off,
                            logic [7:0] wd, logic signed [15:0] pg);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.frame_index <= fi;
        req_ch.byte_offset <= off;
        req_ch.write_data  <= wd;
        req_ch.page_number <= pg;
        // hold until the transfer
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic send_random(int alloc_pct);
        int          pick;
        logic [2:0]  rt;
        logic [7:0]  fi;
        logic [11:0] off;
        pick = $urandom_range(99);
        if (pick < alloc_pct) rt = REQ_ALLOC;
        else begin
            pick = $urandom_range(99);
            if (pick < 20)      rt = REQ_FREE;
            else if (pick < 40) rt = REQ_READ;
            else if (pick < 62) rt = REQ_WRITE;
            else if (pick < 78) rt = REQ_GET_MAP;
            else if (pick < 95) rt = REQ_SET_MAP;
            else if (pick < 98) rt = REQ_RSVD_A;
            else                rt = REQ_RSVD_B;
        end
        fi = ($urandom_range(99) < 88) ? 8'($urandom_range(FRAME_COUNT - 1)) : 8'($urandom);
        // keep many byte accesses in a narrow window so reads hit written bytes
        if ($urandom_range(99) >= 88)     off = 12'($urandom);
        else if ($urandom_range(99) < 45) off = 12'($urandom_range(7));
        else                              off = 12'($urandom_range(FRAME_BYTES - 1));
        send_req(rt, fi, off, 8'($urandom), 16'($urandom));
    endtask

    task automatic run_directed();
        send_req(REQ_ALLOC,   8'd0,   12'd0,    8'h00, 16'sd0);
        send_req(REQ_READ,    8'd0,   12'd0,    8'h00, 16'sd0);
        send_req(REQ_WRITE,   8'd0,   12'd0,    8'hFF, 16'sd0);
        send_req(REQ_WRITE,   8'd15,  12'd255,  8'h5A, 16'sd0);
        send_req(REQ_READ,    8'd0,   12'd0,    8'h00, 16'sd0);
        send_req(REQ_READ,    8'd15,  12'd255,  8'h00, 16'sd0);
        send_req(REQ_READ,    8'd0,   12'd256,  8'h00, 16'sd0);
        send_req(REQ_READ,    8'd0,   12'd4095, 8'h00, 16'sd0);
        send_req(REQ_WRITE,   8'd16,  12'd0,    8'hA5, 16'sd0);
        send_req(REQ_WRITE,   8'd3,   12'd4095, 8'hA5, 16'sd0);
        send_req(REQ_READ,    8'd255, 12'd0,    8'h00, 16'sd0);
        send_req(REQ_GET_MAP, 8'd0,   12'd0,    8'h00, 16'sd0);
        send_req(REQ_SET_MAP, 8'd0,   12'd0,    8'h00, 16'sd32767);
        send_req(REQ_SET_MAP, 8'd15,  12'd0,    8'h00, 16'sh8000);
        send_req(REQ_GET_MAP, 8'd0,   12'd0,    8'h00, 16'sd0);
        send_req(REQ_GET_MAP, 8'd15,  12'd0,    8'h00, 16'sd0);
        send_req(REQ_SET_MAP, 8'd255, 12'd0,    8'h00, 16'sd7);
        send_req(REQ_GET_MAP, 8'd255, 12'd0,    8'h00, 16'sd0);
        send_req(REQ_FREE,    8'd0,   12'd0,    8'h00, 16'sd0);
        send_req(REQ_FREE,    8'd0,   12'd0,    8'h00, 16'sd0);
        send_req(REQ_FREE,    8'd200, 12'd0,    8'h00, 16'sd0);
        send_req(REQ_GET_MAP, 8'd0,   12'd0,    8'h00, 16'sd0);
        send_req(REQ_RSVD_A,  8'd1,   12'd1,    8'h11, 16'sd1);
        send_req(REQ_RSVD_B,  8'd2,   12'd2,    8'h22, 16'sd2);
    endtask

    initial begin
        int alloc_pct;
        board         = new();
        quiet_cycles  = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_ALLOC;
        req_ch.frame_index <= 8'd0;
        req_ch.byte_offset <= 12'd0;
        req_ch.write_data  <= 8'd0;
        req_ch.page_number <= 16'sd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // fill the frames early so victim grants and pointer wrap come soon
        alloc_pct = 60;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
                default: begin src_idle_pct = 36; snk_stall_pct = 36; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 100 == 99) begin
                    case ($urandom_range(2))
                        0:       alloc_pct = 15;
                        1:       alloc_pct = 35;
                        default: alloc_pct = 60;
                    endcase
                end
                send_random(alloc_pct);
            end
        end
        req_ch.valid <= 1'b0;

        // let the monitor note the last transfer before draining
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
